### src/pfs_pkg.sv
package pfs_pkg;

  localparam int ENTRIES_DEFAULT   = 4096;
  localparam int MAX_WIDTH_DEFAULT = 16;
  localparam int WORD_BITS         = 64;
  localparam int INDEX_BITS        = 12;
  localparam int VALUE_BITS        = 16;
  localparam int CFG_BITS          = 5;
  localparam logic [CFG_BITS-1:0] FIELD_WIDTH_RESET = 5'd4;

  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_LO    = 4'b0100,
    S_HI    = 4'b1000
  } state_t;

  function automatic logic [WORD_BITS-1:0] width_mask(input logic [6:0] w);
    logic [WORD_BITS-1:0] m;
    if (w >= 7'd64) begin
      m = '1;
    end else begin
      m = (64'd1 << w) - 64'd1;
    end
    return m;
  endfunction

endpackage

### src/pfs_mem.sv
module pfs_mem #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  logic                          clk,
  input  logic                          rd_en,
  input  logic [ADDR_W-1:0]             rd_addr,
  output logic [pfs_pkg::WORD_BITS-1:0] rd_data,
  input  logic                          wr_en,
  input  logic [ADDR_W-1:0]             wr_addr,
  input  logic [pfs_pkg::WORD_BITS-1:0] wr_data
);

  logic [pfs_pkg::WORD_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### src/pfs_ctrl.sv
module pfs_ctrl #(
  parameter int ENTRIES   = pfs_pkg::ENTRIES_DEFAULT,
  parameter int MAX_WIDTH = pfs_pkg::MAX_WIDTH_DEFAULT,
  parameter int DEPTH     = 1024,
  parameter int ADDR_W    = 10
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [pfs_pkg::CFG_BITS-1:0]   field_width,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           req_type,
  input  logic [pfs_pkg::INDEX_BITS-1:0] field_index,
  input  logic [pfs_pkg::VALUE_BITS-1:0] write_value,
  input  logic                           out_free,
  output logic                           res_valid,
  output logic [pfs_pkg::VALUE_BITS-1:0] res_value,
  output logic                           rd_en,
  output logic [ADDR_W-1:0]              rd_addr,
  input  logic [pfs_pkg::WORD_BITS-1:0]  rd_data,
  output logic                           wr_en,
  output logic [ADDR_W-1:0]              wr_addr,
  output logic [pfs_pkg::WORD_BITS-1:0]  wr_data
);

  localparam int WB    = $clog2(MAX_WIDTH + 1);
  localparam int POS_W = pfs_pkg::INDEX_BITS + WB;

  pfs_pkg::state_t state, state_next;

  logic [ADDR_W-1:0] clr_addr;
  logic              clr_last;

  logic [6:0]        cfg7;
  logic [6:0]        w_clamp;
  logic [WB-1:0]     w_eff;
  logic [POS_W-1:0]  bit_pos;
  logic [5:0]        pos_offset;
  logic [ADDR_W-1:0] pos_word;
  logic              accept;

  logic                          is_write;
  logic                          out_range;
  logic                          straddle;
  logic [5:0]                    offset;
  logic [6:0]                    w_r;
  logic [ADDR_W-1:0]             word_idx;
  logic [pfs_pkg::WORD_BITS-1:0] mask;
  logic [pfs_pkg::WORD_BITS-1:0] value;
  logic [pfs_pkg::WORD_BITS-1:0] lo_word;

  logic [6:0]                    up_shift;
  logic [6:0]                    in_next;
  logic [pfs_pkg::WORD_BITS-1:0] lo_new;
  logic [pfs_pkg::WORD_BITS-1:0] hi_new;
  logic [pfs_pkg::WORD_BITS-1:0] hi_word;
  logic [pfs_pkg::WORD_BITS-1:0] rd_field;

  assign cfg7 = 7'(field_width);

  always_comb begin
    if (cfg7 == 7'd0) begin
      w_clamp = 7'd1;
    end else if (cfg7 > 7'(MAX_WIDTH)) begin
      w_clamp = 7'(MAX_WIDTH);
    end else begin
      w_clamp = cfg7;
    end
  end

  assign w_eff      = WB'(w_clamp);
  assign bit_pos    = POS_W'(field_index) * POS_W'(w_eff);
  assign pos_offset = bit_pos[5:0];
  assign pos_word   = ADDR_W'(bit_pos >> 6);

  assign in_ready = (state == pfs_pkg::S_IDLE);
  assign accept   = in_valid && in_ready;
  assign clr_last = (clr_addr == ADDR_W'(DEPTH - 1));

  assign up_shift = 7'd64 - 7'(offset);
  assign in_next  = 7'(offset) + w_r - 7'd64;
  assign lo_new   = (rd_data & ~(mask << offset)) | (value << offset);
  assign hi_new   = (rd_data & ~pfs_pkg::width_mask(in_next)) | (value >> up_shift);
  assign hi_word  = straddle ? (rd_data << up_shift) : '0;
  assign rd_field = ((lo_word >> offset) | hi_word) & mask;

  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    rd_addr    = pos_word;
    wr_en      = 1'b0;
    wr_addr    = word_idx;
    wr_data    = lo_new;
    res_valid  = 1'b0;
    res_value  = '0;
    case (state)
      pfs_pkg::S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
        wr_data = '0;
        if (clr_last) begin
          state_next = pfs_pkg::S_IDLE;
        end
      end
      pfs_pkg::S_IDLE: begin
        if (accept) begin
          rd_en      = 1'b1;
          state_next = pfs_pkg::S_LO;
        end
      end
      pfs_pkg::S_LO: begin
        rd_en      = straddle;
        rd_addr    = ADDR_W'(word_idx + ADDR_W'(1));
        wr_en      = is_write && !out_range;
        state_next = pfs_pkg::S_HI;
      end
      pfs_pkg::S_HI: begin
        if (out_free) begin
          wr_en      = is_write && straddle && !out_range;
          wr_addr    = ADDR_W'(word_idx + ADDR_W'(1));
          wr_data    = hi_new;
          res_valid  = 1'b1;
          res_value  = (is_write || out_range) ? '0 : rd_field[pfs_pkg::VALUE_BITS-1:0];
          state_next = pfs_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = pfs_pkg::S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= pfs_pkg::S_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == pfs_pkg::S_CLEAR) begin
        clr_addr <= ADDR_W'(clr_addr + ADDR_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      is_write  <= (req_type == pfs_pkg::REQ_WRITE);
      out_range <= (32'(field_index) >= ENTRIES);
      straddle  <= (8'(pos_offset) + 8'(w_clamp)) > 8'd64;
      offset    <= pos_offset;
      w_r       <= w_clamp;
      word_idx  <= pos_word;
      mask      <= pfs_pkg::width_mask(w_clamp);
      value     <= 64'(write_value) & pfs_pkg::width_mask(w_clamp);
    end
    if (state == pfs_pkg::S_LO) begin
      lo_word <= rd_data;
    end
  end

endmodule

### src/packed_field_store_core.sv
// Each request runs through S_IDLE, S_LO and S_HI: the s_tvalid/s_tready transfer issues the low word read,
// S_LO writes the low word back and reads the high one, and S_HI forms the result.
// m_tvalid is registered from the result formed in S_HI, and no new request is taken until the block
// returns to S_IDLE; a result held on m_tvalid without m_tready stalls the block in S_HI.
// After reset the word memory is cleared one word a cycle, ENTRIES*MAX_WIDTH/64 words rounded up
// (1024 by default), while s_tready stays low; field_width resets to 4.
module packed_field_store_core #(
  parameter int ENTRIES   = pfs_pkg::ENTRIES_DEFAULT,
  parameter int MAX_WIDTH = pfs_pkg::MAX_WIDTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // field_index [11:0], write_value [27:12], zero [31:28]
  input  logic [0:0]  s_tuser,   // req_type [0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // read_value [15:0]
);

  localparam int DEPTH  = (ENTRIES * MAX_WIDTH + pfs_pkg::WORD_BITS - 1) / pfs_pkg::WORD_BITS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [pfs_pkg::CFG_BITS-1:0]   field_width;
  logic                           out_free;
  logic                           res_valid;
  logic [pfs_pkg::VALUE_BITS-1:0] res_value;
  logic                           rd_en;
  logic [ADDR_W-1:0]              rd_addr;
  logic [pfs_pkg::WORD_BITS-1:0]  rd_data;
  logic                           wr_en;
  logic [ADDR_W-1:0]              wr_addr;
  logic [pfs_pkg::WORD_BITS-1:0]  wr_data;

  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      field_width <= pfs_pkg::FIELD_WIDTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      field_width <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      m_tdata <= res_value;
    end
  end

  pfs_ctrl #(
    .ENTRIES   (ENTRIES),
    .MAX_WIDTH (MAX_WIDTH),
    .DEPTH     (DEPTH),
    .ADDR_W    (ADDR_W)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .field_width (field_width),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .req_type    (s_tuser[0]),
    .field_index (s_tdata[11:0]),
    .write_value (s_tdata[27:12]),
    .out_free    (out_free),
    .res_valid   (res_valid),
    .res_value   (res_value),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data)
  );

  pfs_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

endmodule

### tb/sv/tb_packed_field_store_core.sv
`timescale 1ns / 100ps

module tb_packed_field_store_core;

  localparam int ENTRIES     = pfs_pkg::ENTRIES_DEFAULT;
  localparam int MAX_WIDTH   = pfs_pkg::MAX_WIDTH_DEFAULT;
  localparam int WORD_BITS   = pfs_pkg::WORD_BITS;
  localparam int INDEX_BITS  = pfs_pkg::INDEX_BITS;
  localparam int VALUE_BITS  = pfs_pkg::VALUE_BITS;
  localparam int CFG_BITS    = pfs_pkg::CFG_BITS;
  localparam int STORE_WORDS = (ENTRIES * MAX_WIDTH + WORD_BITS - 1) / WORD_BITS;
  localparam int PHASE_ITEMS = 88;
  localparam int LONG_HOLD   = 400;

  class field_store_scoreboard;
    logic [WORD_BITS-1:0] words [STORE_WORDS];
    logic [CFG_BITS-1:0]  width_reg;
    logic [VALUE_BITS-1:0] read_value_q[$];
    int errors;

    function new();
      foreach (words[i]) words[i] = '0;
      width_reg = pfs_pkg::FIELD_WIDTH_RESET;
      errors = 0;
    endfunction

    function void set_width(logic [CFG_BITS-1:0] value);
      width_reg = value;
    endfunction

    function logic [WORD_BITS-1:0] word_at(int idx);
      return (idx < STORE_WORDS) ? words[idx] : '0;
    endfunction

    // Works out the field a request reads, or applies the masked write to one or two words.
    function void note_request(logic kind, logic [INDEX_BITS-1:0] idx,
                               logic [VALUE_BITS-1:0] value);
      int w;
      int bit_pos;
      int word_idx;
      int offset;
      bit straddle;
      logic [WORD_BITS-1:0] mask;
      logic [WORD_BITS-1:0] v;
      logic [WORD_BITS-1:0] lo;
      logic [WORD_BITS-1:0] hi;
      logic [WORD_BITS-1:0] field;
      w = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg));
      mask = (w >= WORD_BITS) ? '1 : (64'd1 << w) - 64'd1;
      field = '0;
      if (idx < ENTRIES) begin
        bit_pos = int'(idx) * w;
        word_idx = bit_pos / WORD_BITS;
        offset = bit_pos % WORD_BITS;
        straddle = (offset + w) > WORD_BITS;
        if (kind == pfs_pkg::REQ_READ) begin
          v = word_at(word_idx) >> offset;
          if (straddle) v = v | (word_at(word_idx + 1) << (WORD_BITS - offset));
          field = v & mask;
        end else begin
          v = {48'd0, value} & mask;
          lo = (word_at(word_idx) & ~(mask << offset)) | (v << offset);
          if (word_idx < STORE_WORDS) words[word_idx] = lo;
          if (straddle) begin
            hi = word_at(word_idx + 1);
            hi = (hi & ~((64'd1 << (offset + w - WORD_BITS)) - 64'd1)) |
                 (v >> (WORD_BITS - offset));
            if (word_idx + 1 < STORE_WORDS) words[word_idx + 1] = hi;
          end
        end
      end
      read_value_q.push_back(field[VALUE_BITS-1:0]);
    endfunction

    function void check_result(logic [VALUE_BITS-1:0] got);
      logic [VALUE_BITS-1:0] want;
      if (read_value_q.size() == 0) begin
        errors++;
        $display("%0t: read_value expected none, actual %h", $time, got);
      end else begin
        want = read_value_q.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: read_value expected %h, actual %h", $time, want, got);
        end
      end
    endfunction

    function int pending();
      return read_value_q.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [4:0]  cfg_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;
  logic [0:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;

  field_store_scoreboard sb = new();

  int tx_run = 0;
  int tx_mode = 0;
  int rx_run = 0;
  int rx_mode = 0;
  int rx_count = 0;

  packed_field_store_core #(
    .ENTRIES   (ENTRIES),
    .MAX_WIDTH (MAX_WIDTH)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Idle cycles come in runs: some with no gaps, some short, some up to the full range.
  function automatic int draw_gap(inout int run, inout int mode);
    if (run == 0) begin
      run = $urandom_range(8, 40);
      mode = $urandom_range(0, 2);
    end
    run--;
    if (mode == 0) return 0;
    if (mode == 1) return $urandom_range(0, 16);
    return $urandom_range(0, 3);
  endfunction

  always @(posedge clk) begin
    if (cfg_valid && cfg_ready) sb.set_width(cfg_data);
    if (s_tvalid && s_tready) sb.note_request(s_tuser[0], s_tdata[11:0], s_tdata[27:12]);
    if (m_tvalid && m_tready) sb.check_result(m_tdata);
  end

  // The receiver stalls once for a long stretch so that the block backs up onto its input.
  initial begin
    int gap;
    m_tready = 1'b0;
    @(posedge clk);
    forever begin
      gap = draw_gap(rx_run, rx_mode);
      if (rx_count == 200) gap = LONG_HOLD;
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      rx_count++;
    end
  end

  task automatic send_req(input logic kind, input logic [INDEX_BITS-1:0] idx,
                          input logic [VALUE_BITS-1:0] value);
    int gap;
    gap = draw_gap(tx_run, tx_mode);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= {4'd0, value, idx};
    do @(posedge clk); while (!s_tready);
  endtask

  // Waits until every result has come back before the field width is changed.
  task automatic write_field_width(input logic [CFG_BITS-1:0] value);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [CFG_BITS-1:0] phase_widths [12];
    int hot_base;
    logic [INDEX_BITS-1:0] idx;
    phase_widths = '{5'd16, 5'd1, 5'd0, 5'd5, 5'd7, 5'd13, 5'd31, 5'd3, 5'd12, 5'd17,
                     5'd9, 5'd15};
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send_req(pfs_pkg::REQ_READ, 12'd0, 16'h0000);
    send_req(pfs_pkg::REQ_WRITE, 12'd0, 16'hFFFF);
    send_req(pfs_pkg::REQ_WRITE, 12'd4095, 16'hFFFF);
    send_req(pfs_pkg::REQ_READ, 12'd0, 16'h0000);
    send_req(pfs_pkg::REQ_READ, 12'd4095, 16'hFFFF);
    send_req(pfs_pkg::REQ_READ, 12'd1, 16'h0000);
    send_req(pfs_pkg::REQ_WRITE, 12'd1, 16'hA5A5);
    send_req(pfs_pkg::REQ_READ, 12'd1, 16'h0000);

    // At a width of 13, field 4 straddles the first two words.
    write_field_width(5'd13);
    send_req(pfs_pkg::REQ_WRITE, 12'd4, 16'hFFFF);
    send_req(pfs_pkg::REQ_READ, 12'd4, 16'h0000);
    send_req(pfs_pkg::REQ_READ, 12'd3, 16'h0000);
    send_req(pfs_pkg::REQ_READ, 12'd5, 16'h0000);
    send_req(pfs_pkg::REQ_WRITE, 12'd4, 16'h0000);
    send_req(pfs_pkg::REQ_READ, 12'd4, 16'h0000);
    send_req(pfs_pkg::REQ_WRITE, 12'd4095, 16'h1234);
    send_req(pfs_pkg::REQ_READ, 12'd4095, 16'h0000);

    write_field_width(5'd0);
    send_req(pfs_pkg::REQ_READ, 12'd0, 16'h0000);
    send_req(pfs_pkg::REQ_WRITE, 12'd4095, 16'h0000);
    send_req(pfs_pkg::REQ_READ, 12'd63, 16'h0000);

    write_field_width(5'd31);
    send_req(pfs_pkg::REQ_WRITE, 12'd4095, 16'hFFFF);
    send_req(pfs_pkg::REQ_READ, 12'd4095, 16'h0000);
    send_req(pfs_pkg::REQ_WRITE, 12'd0, 16'h8001);
    send_req(pfs_pkg::REQ_READ, 12'd0, 16'h0000);

    write_field_width(5'd16);
    send_req(pfs_pkg::REQ_READ, 12'd4095, 16'h0000);

    write_field_width(5'd17);
    send_req(pfs_pkg::REQ_READ, 12'd0, 16'h0000);

    // Most accesses fall in a small window so that reads find data written earlier.
    foreach (phase_widths[p]) begin
      write_field_width(phase_widths[p]);
      hot_base = $urandom_range(0, ENTRIES - 64);
      repeat (PHASE_ITEMS) begin
        if ($urandom_range(0, 3) != 0) idx = INDEX_BITS'(hot_base + $urandom_range(0, 63));
        else idx = INDEX_BITS'($urandom_range(0, ENTRIES - 1));
        send_req(1'($urandom_range(0, 1)), idx, VALUE_BITS'($urandom_range(0, 65535)));
      end
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
